// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/tsm_pkg.sv -----
// ----------------------------------------------------------------------------
// tsm_pkg
// Request codes and calendar constants of the schedule matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package tsm_pkg;

    typedef enum logic [2:0] {
        FN_TICK   = 3'd0,
        FN_QUERY  = 3'd1,
        FN_HEADER = 3'd2,
        FN_START  = 3'd3,
        FN_END    = 3'd4,
        FN_JOB    = 3'd5,
        FN_ACTION = 3'd6,
        FN_DELETE = 3'd7
    } func_t;

    localparam logic [15:0] MIN_YEAR     = 16'd2020;
    localparam logic [15:0] YEARLY       = 16'hFFFF;
    localparam logic [11:0] DAY_MINUTES  = 12'd1440;
    localparam logic [10:0] HOUR_MINUTES = 11'd60;

    // weekday mask bit: (weekday + 5) mod 7
    function automatic logic [2:0] week_bit(input logic [2:0] wd);
        logic [2:0] r;
        unique case (wd)
            3'd0: r = 3'd5;
            3'd1: r = 3'd6;
            3'd2: r = 3'd0;
            3'd3: r = 3'd1;
            3'd4: r = 3'd2;
            3'd5: r = 3'd3;
            3'd6: r = 3'd4;
            default: r = 3'd5;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tsm_ram.sv -----
// ----------------------------------------------------------------------------
// tsm_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    aclk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/timed_schedule_matcher.sv -----
// ----------------------------------------------------------------------------
// timed_schedule_matcher
// Table of timed plans; matches the current time against every action.
// ----------------------------------------------------------------------------
// Write requests: result presented the cycle after acceptance.
// Tick/query: the scan steps through plans, jobs and actions, with one job RAM
// and one action RAM read per step, then presents the best match.
// One request at a time; next request taken once the result is delivered.
// Reset clears plan valid bits, the last-fired record and the handshake.
`default_nettype none
`include "assert_macros.svh"

module timed_schedule_matcher #(
    parameter int PLAN_COUNT      = 8,
    parameter int JOBS_PER_PLAN   = 4,
    parameter int ACTIONS_PER_JOB = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // slot[7:0] year[23:8] month[27:24] day[32:28] hour[37:33] minute[43:38]
    // second[49:44] weekday[52:50] rtc_ready[53] channel[55:54] data[73:56]
    input  wire logic [79:0] s_tdata,
    // func[2:0]
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // found[0] apply[1] plan_id[5:2] job_number[7:6] action_number[10:8]
    // priority_res[14:11] brightness[21:15]
    output logic [23:0]      m_tdata
);

    import tsm_pkg::*;

    localparam int JOB_SLOTS    = PLAN_COUNT * JOBS_PER_PLAN;
    localparam int ACTION_SLOTS = JOB_SLOTS * ACTIONS_PER_JOB;
    localparam int PW  = (PLAN_COUNT > 1) ? $clog2(PLAN_COUNT) : 1;
    localparam int PCW = $clog2(PLAN_COUNT + 1);
    localparam int JW  = (JOBS_PER_PLAN > 1) ? $clog2(JOBS_PER_PLAN) : 1;
    localparam int JCW = $clog2(JOBS_PER_PLAN + 1);
    localparam int AW  = (ACTIONS_PER_JOB > 1) ? $clog2(ACTIONS_PER_JOB) : 1;
    localparam int ACW = $clog2(ACTIONS_PER_JOB + 1);
    localparam int JAW = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
    localparam int AAW = (ACTION_SLOTS > 1) ? $clog2(ACTION_SLOTS) : 1;

    typedef enum logic [1:0] {S_IDLE, S_PLAN, S_JOB, S_ACT} state_t;

    // request fields
    func_t       in_func;
    logic [7:0]  in_slot;
    logic [15:0] in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
    logic [4:0]  in_hour;
    logic [5:0]  in_minute;
    logic [5:0]  in_second;
    logic [2:0]  in_weekday;
    logic        in_rtc;
    logic [1:0]  in_channel;
    logic [17:0] in_data;
    logic [41:0] in_now;
    logic [10:0] in_cur;
    logic        clock_ok;
    logic        accept;

    assign in_func    = func_t'(s_tuser);
    assign in_slot    = s_tdata[7:0];
    assign in_year    = s_tdata[23:8];
    assign in_month   = s_tdata[27:24];
    assign in_day     = s_tdata[32:28];
    assign in_hour    = s_tdata[37:33];
    assign in_minute  = s_tdata[43:38];
    assign in_second  = s_tdata[49:44];
    assign in_weekday = s_tdata[52:50];
    assign in_rtc     = s_tdata[53];
    assign in_channel = s_tdata[55:54];
    assign in_data    = s_tdata[73:56];
    assign in_now     = {in_year, in_month, in_day, in_hour, in_minute, in_second};
    assign in_cur     = ({6'd0, in_hour} * HOUR_MINUTES) + {5'd0, in_minute};
    assign clock_ok   = in_rtc && (in_year >= MIN_YEAR) && (in_month >= 4'd1)
                        && (in_month <= 4'd12) && (in_day != 5'd0)
                        && (in_hour <= 5'd23) && (in_minute <= 6'd59);

    // state
    state_t          state_reg;
    logic [PCW-1:0]  p_reg;
    logic [JCW-1:0]  j_reg;
    logic [JCW-1:0]  jlim_reg;
    logic [ACW-1:0]  a_reg;
    logic [ACW-1:0]  alim_reg;
    logic [3:0]      prio_reg;
    logic [41:0]     now_reg;
    logic [10:0]     cur_reg;
    logic [2:0]      widx_reg;
    logic [1:0]      chan_reg;
    logic            tick_reg;
    logic            best_hit_reg;
    logic [PW-1:0]   best_p_reg;
    logic [JW-1:0]   best_j_reg;
    logic [AW-1:0]   best_a_reg;
    logic [3:0]      best_prio_reg;
    logic [6:0]      best_bri_reg;
    logic            hdr_valid_reg [PLAN_COUNT];
    logic [14:0]     hdr_reg       [PLAN_COUNT];
    logic [41:0]     start_reg     [PLAN_COUNT];
    logic [41:0]     end_reg       [PLAN_COUNT];
    logic            exec_valid_reg;
    logic [24:0]     exec_date_reg;
    logic [10:0]     exec_min_reg;
    logic [PW-1:0]   exec_p_reg;
    logic [JW-1:0]   exec_j_reg;
    logic [AW-1:0]   exec_a_reg;
    logic            m_valid_reg;
    logic [21:0]     out_reg;

    // memories
    logic            job_we;
    logic [JAW-1:0]  job_raddr;
    logic [5:0]      job_rdata;
    logic            act_we;
    logic [AAW-1:0]  act_raddr;
    logic [17:0]     act_rdata;

    // scan decode
    logic [PW-1:0]   p_idx;
    logic [14:0]     hdr_cur;
    logic [41:0]     s_cur;
    logic [41:0]     e_cur;
    logic            date_ok;
    logic [6:0]      plan_days;
    logic            plan_ok;
    logic            scan_end;
    logic [JCW-1:0]  jlim_calc;
    logic [ACW-1:0]  alim_calc;
    logic            chan_ok;
    logic [JCW-1:0]  j_step;
    logic [ACW-1:0]  a_step;
    logic [JCW-1:0]  job_sel;
    logic [ACW-1:0]  act_sel;
    logic [10:0]     am;
    logic [11:0]     am_inc;
    logic            act_hit;
    logic            better;
    logic            repeat_hit;
    logic            apply;

    assign s_tready = (state_reg == S_IDLE) && !m_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'd0, out_reg};

    assign p_idx     = p_reg[PW-1:0];
    assign hdr_cur   = hdr_reg[p_idx];
    assign s_cur     = start_reg[p_idx];
    assign e_cur     = end_reg[p_idx];
    assign plan_days = hdr_cur[11:5];

    always_comb begin
        if (s_cur[41:26] == YEARLY) begin
            if (s_cur[25:0] <= e_cur[25:0]) begin
                date_ok = (now_reg[25:0] >= s_cur[25:0]) && (now_reg[25:0] <= e_cur[25:0]);
            end else begin
                date_ok = (now_reg[25:0] >= s_cur[25:0]) || (now_reg[25:0] <= e_cur[25:0]);
            end
        end else begin
            date_ok = (now_reg >= s_cur) && (now_reg <= e_cur);
        end
    end

    assign scan_end  = (p_reg == PCW'(PLAN_COUNT));
    assign plan_ok   = hdr_valid_reg[p_idx] && hdr_cur[0] && date_ok && plan_days[widx_reg];
    assign jlim_calc = (int'(hdr_cur[14:12]) >= JOBS_PER_PLAN) ? JCW'(JOBS_PER_PLAN)
                                                               : JCW'(hdr_cur[14:12]);
    assign alim_calc = (int'(job_rdata[5:2]) >= ACTIONS_PER_JOB) ? ACW'(ACTIONS_PER_JOB)
                                                                 : ACW'(job_rdata[5:2]);
    assign chan_ok   = !((chan_reg == 2'd1) && !job_rdata[0])
                       && !((chan_reg == 2'd2) && !job_rdata[1]);
    assign j_step    = j_reg + JCW'(1);
    assign a_step    = a_reg + ACW'(1);
    assign job_sel   = (state_reg == S_PLAN) ? '0 : j_step;
    assign act_sel   = (state_reg == S_JOB) ? '0 : a_step;
    assign job_raddr = JAW'(int'(p_idx) * JOBS_PER_PLAN + int'(job_sel));
    assign act_raddr = AAW'((int'(p_idx) * JOBS_PER_PLAN + int'(j_reg)) * ACTIONS_PER_JOB
                            + int'(act_sel));

    assign am      = act_rdata[10:0];
    assign am_inc  = ({1'b0, am} + 12'd1 >= DAY_MINUTES) ? ({1'b0, am} + 12'd1 - DAY_MINUTES)
                                                        : ({1'b0, am} + 12'd1);
    assign act_hit = (am == cur_reg) || (am_inc == {1'b0, cur_reg});
    assign better  = act_hit && (!best_hit_reg || (prio_reg > best_prio_reg));

    assign repeat_hit = exec_valid_reg && (exec_date_reg == now_reg[41:17])
                        && (exec_min_reg == cur_reg) && (exec_p_reg == best_p_reg)
                        && (exec_j_reg == best_j_reg) && (exec_a_reg == best_a_reg);
    assign apply = tick_reg && best_hit_reg && !repeat_hit;

    assign job_we = accept && (in_func == FN_JOB) && (int'(in_slot) < JOB_SLOTS);
    assign act_we = accept && (in_func == FN_ACTION) && (int'(in_slot) < ACTION_SLOTS);

    tsm_ram #(.WIDTH(6), .DEPTH(JOB_SLOTS)) u_job_ram (
        .aclk  (aclk),
        .we    (job_we),
        .waddr (JAW'(in_slot)),
        .wdata (in_data[5:0]),
        .raddr (job_raddr),
        .rdata (job_rdata)
    );

    tsm_ram #(.WIDTH(18), .DEPTH(ACTION_SLOTS)) u_act_ram (
        .aclk  (aclk),
        .we    (act_we),
        .waddr (AAW'(in_slot)),
        .wdata (in_data),
        .raddr (act_raddr),
        .rdata (act_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_valid_reg    <= 1'b0;
            exec_valid_reg <= 1'b0;
            for (int i = 0; i < PLAN_COUNT; i++) begin
                hdr_valid_reg[i] <= 1'b0;
            end
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        if ((in_func == FN_TICK) || (in_func == FN_QUERY)) begin
                            if (clock_ok) begin
                                now_reg      <= in_now;
                                cur_reg      <= in_cur;
                                widx_reg     <= week_bit(in_weekday);
                                chan_reg     <= (in_func == FN_TICK) ? 2'd0 : in_channel;
                                tick_reg     <= (in_func == FN_TICK);
                                best_hit_reg <= 1'b0;
                                p_reg        <= '0;
                                state_reg    <= S_PLAN;
                            end else begin
                                out_reg     <= '0;
                                m_valid_reg <= 1'b1;
                            end
                        end else begin
                            out_reg     <= '0;
                            m_valid_reg <= 1'b1;
                            if (int'(in_slot) < PLAN_COUNT) begin
                                unique case (in_func)
                                    FN_HEADER: begin
                                        hdr_reg[in_slot[PW-1:0]]       <= in_data[14:0];
                                        hdr_valid_reg[in_slot[PW-1:0]] <= 1'b1;
                                        exec_valid_reg                 <= 1'b0;
                                    end
                                    FN_START: begin
                                        start_reg[in_slot[PW-1:0]] <= in_now;
                                        exec_valid_reg             <= 1'b0;
                                    end
                                    FN_END: begin
                                        end_reg[in_slot[PW-1:0]] <= in_now;
                                        exec_valid_reg           <= 1'b0;
                                    end
                                    FN_DELETE: begin
                                        if (hdr_valid_reg[in_slot[PW-1:0]]) begin
                                            hdr_valid_reg[in_slot[PW-1:0]] <= 1'b0;
                                            exec_valid_reg                 <= 1'b0;
                                        end
                                    end
                                    default: begin
                                    end
                                endcase
                            end
                            if (job_we || act_we) begin
                                exec_valid_reg <= 1'b0;
                            end
                        end
                    end
                end
                S_PLAN: begin
                    if (scan_end) begin
                        out_reg <= best_hit_reg ?
                            {best_bri_reg, best_prio_reg, 3'(best_a_reg), 2'(best_j_reg),
                             4'(int'(best_p_reg) + 1), apply, 1'b1} : '0;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                        if (apply) begin
                            exec_valid_reg <= 1'b1;
                            exec_date_reg  <= now_reg[41:17];
                            exec_min_reg   <= cur_reg;
                            exec_p_reg     <= best_p_reg;
                            exec_j_reg     <= best_j_reg;
                            exec_a_reg     <= best_a_reg;
                        end
                    end else if (plan_ok && (jlim_calc != '0)) begin
                        jlim_reg  <= jlim_calc;
                        prio_reg  <= hdr_cur[4:1];
                        j_reg     <= '0;
                        state_reg <= S_JOB;
                    end else begin
                        p_reg <= p_reg + PCW'(1);
                    end
                end
                S_JOB: begin
                    if (chan_ok && (alim_calc != '0)) begin
                        alim_reg  <= alim_calc;
                        a_reg     <= '0;
                        state_reg <= S_ACT;
                    end else if (j_step < jlim_reg) begin
                        j_reg <= j_step;
                    end else begin
                        p_reg     <= p_reg + PCW'(1);
                        state_reg <= S_PLAN;
                    end
                end
                S_ACT: begin
                    if (better) begin
                        best_hit_reg  <= 1'b1;
                        best_p_reg    <= p_idx;
                        best_j_reg    <= j_reg[JW-1:0];
                        best_a_reg    <= a_reg[AW-1:0];
                        best_prio_reg <= prio_reg;
                        best_bri_reg  <= act_rdata[17:11];
                    end
                    if (a_step < alim_reg) begin
                        a_reg <= a_step;
                    end else if (j_step < jlim_reg) begin
                        j_reg     <= j_step;
                        state_reg <= S_JOB;
                    end else begin
                        p_reg     <= p_reg + PCW'(1);
                        state_reg <= S_PLAN;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_NOW(a_apply_found, aclk, aresetn, m_tvalid && m_tdata[1], m_tdata[0],
                "apply without a match")
    `ASSERT_NEXT(a_write_result, aclk, aresetn,
                 accept && (in_func != FN_TICK) && (in_func != FN_QUERY), m_tvalid,
                 "write request gave no result")
    `ASSERT_NOW(a_busy_no_take, aclk, aresetn, state_reg != S_IDLE, !s_tready,
                "request taken during scan")

endmodule

`default_nettype wire

// ----- verif/tb_timed_schedule_matcher.sv -----
// ----------------------------------------------------------------------------
// tb_timed_schedule_matcher
// Self-checking bench for the timed schedule matcher. The plan table is filled
// with random content, then directed corner requests and random write, tick
// and query requests are streamed through the block under several idle
// patterns. A behavioral copy of the matcher predicts every result, which is
// compared field by field in arrival order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_timed_schedule_matcher;
    timeunit 1ns;
    timeprecision 1ps;

    import tsm_pkg::*;

    localparam int NPLAN = 8;
    localparam int NJOB  = 4;
    localparam int NACT  = 8;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        func_t       func;
        logic [7:0]  slot;
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
        logic        rtc_ready;
        logic [1:0]  channel;
        logic [17:0] data;
    } sched_req_t;

    // first member lands in the top bits: brightness high, found low
    typedef struct packed {
        logic [6:0] brightness;
        logic [3:0] priority_res;
        logic [2:0] action_number;
        logic [1:0] job_number;
        logic [3:0] plan_id;
        logic       apply;
        logic       found;
    } match_res_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    timed_schedule_matcher u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // matcher state mirror
    logic [15:0] hdr_tbl [NPLAN];
    logic [41:0] start_tbl [NPLAN];
    logic [41:0] end_tbl [NPLAN];
    logic [5:0]  job_tbl [NPLAN*NJOB];
    logic [17:0] act_tbl [NPLAN*NJOB*NACT];
    logic        fired_valid;
    logic [24:0] fired_date;
    int          fired_minute;
    int          fired_plan, fired_job, fired_action;

    // generator-side copy of action minutes for aimed scans
    logic [10:0] gen_act_min [NPLAN*NJOB*NACT];

    sched_req_t  pending_reqs [$];
    match_res_t  expected_matches [$];
    sched_req_t  last_scan;

    int  sender_idle_pct;
    int  receiver_stall_pct;
    int  mismatches;
    int  cycles;
    bit  req_taken;

    function automatic logic [41:0] pack_now(sched_req_t r);
        return {r.year, r.month, r.day, r.hour, r.minute, r.second};
    endfunction

    function automatic bit in_window(int p, logic [41:0] now);
        logic [41:0] s, e;
        logic [25:0] n;
        s = start_tbl[p];
        e = end_tbl[p];
        n = now[25:0];
        if (s[41:26] == YEARLY) begin
            if (s[25:0] <= e[25:0])
                return n >= s[25:0] && n <= e[25:0];
            return n >= s[25:0] || n <= e[25:0];
        end
        return now >= s && now <= e;
    endfunction

    function automatic match_res_t predict_match(sched_req_t r);
        match_res_t res;
        int cur, widx, prio, njobs, nacts, js, am, chan;
        bit hit;
        logic [17:0] ae;
        logic [24:0] date;
        logic [41:0] now_v;
        res = '0;
        hit = 0;
        prio = 0;
        if (r.func == FN_TICK || r.func == FN_QUERY) begin
            chan = (r.func == FN_TICK) ? 0 : int'(r.channel);
            if (r.rtc_ready && r.year >= MIN_YEAR && r.month >= 1 && r.month <= 12 &&
                r.day >= 1 && r.hour <= 23 && r.minute <= 59) begin
                cur = int'(r.hour) * 60 + int'(r.minute);
                widx = (int'(r.weekday) + 5) % 7;
                for (int p = 0; p < NPLAN; p++) begin
                    if (!hdr_tbl[p][15] || !hdr_tbl[p][0]) continue;
                    if (!in_window(p, pack_now(r)) || !hdr_tbl[p][5+widx]) continue;
                    njobs = int'(hdr_tbl[p][14:12]);
                    for (int j = 0; j < njobs && j < NJOB; j++) begin
                        js = p*NJOB + j;
                        if ((chan == 1 || chan == 2) && !job_tbl[js][chan-1]) continue;
                        nacts = int'(job_tbl[js][5:2]);
                        for (int a = 0; a < nacts && a < NACT; a++) begin
                            ae = act_tbl[js*NACT + a];
                            am = int'(ae[10:0]);
                            if (am != cur && (am + 1) % 1440 != cur) continue;
                            if (!hit || int'(hdr_tbl[p][4:1]) > prio) begin
                                hit = 1;
                                prio = int'(hdr_tbl[p][4:1]);
                                res.found = 1'b1;
                                res.plan_id = 4'(p + 1);
                                res.job_number = 2'(j);
                                res.action_number = 3'(a);
                                res.priority_res = 4'(prio);
                                res.brightness = ae[17:11];
                            end
                        end
                    end
                end
                if (hit && r.func == FN_TICK) begin
                    now_v = pack_now(r);
                    date = now_v[41:17];
                    if (!(fired_valid && fired_date == date && fired_minute == cur &&
                          fired_plan == int'(res.plan_id) - 1 &&
                          fired_job == int'(res.job_number) &&
                          fired_action == int'(res.action_number))) begin
                        res.apply = 1'b1;
                        fired_valid = 1;
                        fired_date = date;
                        fired_minute = cur;
                        fired_plan = int'(res.plan_id) - 1;
                        fired_job = int'(res.job_number);
                        fired_action = int'(res.action_number);
                    end
                end
            end
            return res;
        end
        case (r.func)
            FN_HEADER: begin
                if (r.slot >= NPLAN) return res;
                hdr_tbl[r.slot] = {1'b1, r.data[14:0]};
            end
            FN_START: begin
                if (r.slot >= NPLAN) return res;
                start_tbl[r.slot] = pack_now(r);
            end
            FN_END: begin
                if (r.slot >= NPLAN) return res;
                end_tbl[r.slot] = pack_now(r);
            end
            FN_JOB: begin
                if (r.slot >= NPLAN*NJOB) return res;
                job_tbl[r.slot] = r.data[5:0];
            end
            FN_ACTION: act_tbl[r.slot] = r.data;
            default: begin
                if (r.slot >= NPLAN || !hdr_tbl[r.slot][15]) return res;
                hdr_tbl[r.slot][15] = 1'b0;
            end
        endcase
        fired_valid = 0;
        return res;
    endfunction

    function automatic sched_req_t set_when(sched_req_t r, int yr, int mo, int dy, int mn);
        r.year = 16'(yr);
        r.month = 4'(mo);
        r.day = 5'(dy);
        r.hour = 5'(mn / 60);
        r.minute = 6'(mn % 60);
        r.second = 6'($urandom_range(59));
        return r;
    endfunction

    task automatic push_write(func_t f, int slot, logic [17:0] data);
        sched_req_t r;
        r = '0;
        r.func = f;
        r.slot = 8'(slot);
        r.data = data;
        r.weekday = 3'($urandom_range(7));
        r.channel = 2'($urandom_range(3));
        if (f == FN_ACTION) gen_act_min[slot] = data[10:0];
        pending_reqs.push_back(r);
    endtask

    task automatic push_date(func_t f, int slot, int yr, int mo, int dy, int mn);
        sched_req_t r;
        r = '0;
        r.func = f;
        r.slot = 8'(slot);
        r = set_when(r, yr, mo, dy, mn);
        pending_reqs.push_back(r);
    endtask

    task automatic push_header(int p);
        logic [17:0] d;
        d = 18'($urandom);
        d[0] = ($urandom_range(9) != 0);
        if ($urandom_range(3) != 0) d[11:5] = 7'h7F;
        if ($urandom_range(4) != 0) d[14:12] = 3'($urandom_range(4, 1));
        push_write(FN_HEADER, p, d);
    endtask

    task automatic push_window(int p);
        int y;
        if ($urandom_range(1)) begin
            push_date(FN_START, p, 16'hFFFF, $urandom_range(12, 1),
                      $urandom_range(31, 1), $urandom_range(1439));
            push_date(FN_END, p, $urandom_range(65535), $urandom_range(12, 1),
                      $urandom_range(31, 1), $urandom_range(1439));
        end else begin
            y = $urandom_range(2026, 2020);
            push_date(FN_START, p, y, $urandom_range(12, 1), $urandom_range(28, 1),
                      $urandom_range(1439));
            push_date(FN_END, p, y + $urandom_range(9), $urandom_range(12, 1),
                      $urandom_range(31, 1), $urandom_range(1439));
        end
    endtask

    task automatic push_action(int slot);
        logic [17:0] d;
        d = 18'($urandom);
        if ($urandom_range(9) != 0) d[10:0] = 11'($urandom_range(1439));
        if ($urandom_range(3) != 0) d[17:11] = 7'($urandom_range(10, 1) * 10);
        push_write(FN_ACTION, slot, d);
    endtask

    task automatic push_job(int slot);
        logic [5:0] d;
        d = 6'($urandom);
        if ($urandom_range(3) != 0) d[5:2] = 4'($urandom_range(8, 1));
        push_write(FN_JOB, slot, 18'(d) | (18'($urandom) & 18'h3FFC0));
    endtask

    task automatic push_scan(func_t f);
        sched_req_t r;
        int idx, mn;
        if (f == FN_TICK && $urandom_range(3) == 0 &&
            last_scan.func inside {FN_TICK, FN_QUERY}) begin
            r = last_scan;
            r.func = FN_TICK;
        end else begin
            r = '0;
            r.func = f;
            idx = $urandom_range(NPLAN*NJOB*NACT - 1);
            mn = int'(gen_act_min[idx]);
            if (mn >= 1440 || $urandom_range(7) == 0) mn = $urandom_range(1439);
            else if ($urandom_range(1)) mn = (mn + 1) % 1440;
            r = set_when(r, $urandom_range(2035, 2020), $urandom_range(12, 1),
                         $urandom_range(31, 1), mn);
            r.weekday = 3'($urandom_range(7));
            r.rtc_ready = ($urandom_range(19) != 0);
            r.channel = 2'($urandom_range(3));
            r.slot = 8'($urandom);
            r.data = 18'($urandom);
            if ($urandom_range(19) == 0) begin
                r.year = 16'($urandom);
                r.month = 4'($urandom);
                r.day = 5'($urandom);
                r.hour = 5'($urandom);
                r.minute = 6'($urandom);
                r.second = 6'($urandom);
            end
        end
        last_scan = r;
        pending_reqs.push_back(r);
    endtask

    task automatic push_random(int n);
        int k, p;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            p = $urandom_range(NPLAN - 1);
            if (k < 40) push_scan(FN_TICK);
            else if (k < 75) push_scan(FN_QUERY);
            else if (k < 85) push_action($urandom_range(255));
            else if (k < 89) push_job($urandom_range(NPLAN*NJOB + 3));
            else if (k < 93) push_header($urandom_range(9) == 0 ? $urandom_range(255) : p);
            else if (k < 97) push_window(p);
            else begin
                push_write(FN_DELETE, $urandom_range(9) == 0 ? $urandom_range(255) : p,
                           18'($urandom));
                push_header(p);
            end
        end
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || expected_matches.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
            if (!s_tvalid || req_taken) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    s_tuser  <= pending_reqs[0].func;
                    s_tdata  <= {6'd0, pending_reqs[0].data, pending_reqs[0].channel,
                                 pending_reqs[0].rtc_ready, pending_reqs[0].weekday,
                                 pending_reqs[0].second, pending_reqs[0].minute,
                                 pending_reqs[0].hour, pending_reqs[0].day,
                                 pending_reqs[0].month, pending_reqs[0].year,
                                 pending_reqs[0].slot};
                    s_tvalid <= 1'b1;
                    void'(pending_reqs.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        sched_req_t r;
        match_res_t got, want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL timed_schedule_matcher");
            $finish;
        end
        req_taken = aresetn && s_tvalid && s_tready;
        if (req_taken) begin
            r.func = func_t'(s_tuser);
            {r.data, r.channel, r.rtc_ready, r.weekday, r.second, r.minute, r.hour,
             r.day, r.month, r.year, r.slot} = s_tdata[73:0];
            expected_matches.push_back(predict_match(r));
        end
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[21:0];
            if (expected_matches.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = expected_matches.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    initial begin
        int phase;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        mismatches = 0;
        cycles = 0;
        req_taken = 0;
        fired_valid = 0;
        last_scan = '0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        for (int p = 0; p < NPLAN; p++) begin
            hdr_tbl[p] = '0;
            start_tbl[p] = '0;
            end_tbl[p] = '0;
        end
        foreach (job_tbl[i]) job_tbl[i] = '0;
        foreach (act_tbl[i]) act_tbl[i] = '0;
        foreach (gen_act_min[i]) gen_act_min[i] = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // scans before any plan exists
        push_scan(FN_QUERY);
        push_scan(FN_TICK);
        foreach (act_tbl[i]) push_action(i);
        for (int i = 0; i < NPLAN*NJOB; i++) push_job(i);
        for (int p = 0; p < NPLAN; p++) push_window(p);

        // plan 0: yearly wrap window, every weekday, action at last minute of day
        push_date(FN_START, 0, 16'hFFFF, 12, 31, 1000);
        push_date(FN_END, 0, 2020, 1, 2, 10);
        push_write(FN_HEADER, 0, 18'h3_1FF1);
        push_write(FN_JOB, 0, 18'h3FFE3);
        push_write(FN_ACTION, 0, {7'd100, 11'd1439});
        push_write(FN_HEADER, 255, 18'h3FFFF);
        push_write(FN_JOB, 32, 18'h3F);
        push_write(FN_DELETE, 9, 18'd0);
        push_write(FN_DELETE, 1, 18'd0);
        push_write(FN_DELETE, 1, 18'd0);
        push_date(FN_START, 8, 16'hFFFF, 15, 31, 0);
        for (int p = 1; p < NPLAN; p++) push_header(p);
        begin
            sched_req_t r;
            r = '0;
            r.rtc_ready = 1'b1;
            r.weekday = 3'd7;
            r.channel = 2'd3;
            r = set_when(r, 2024, 12, 31, 1439);
            r.func = FN_TICK;  pending_reqs.push_back(r);
            pending_reqs.push_back(r);
            r = set_when(r, 2025, 1, 1, 0);
            pending_reqs.push_back(r);
            r.func = FN_QUERY; pending_reqs.push_back(r);
            r.year = 16'hFFFF; pending_reqs.push_back(r);
            r.rtc_ready = 1'b0;   pending_reqs.push_back(r);
            r.rtc_ready = 1'b1; r.year = 16'd2019; pending_reqs.push_back(r);
            r.year = 16'd2025; r.month = 4'd0;  pending_reqs.push_back(r);
            r.month = 4'd13; pending_reqs.push_back(r);
            r.month = 4'd1; r.day = 5'd0; pending_reqs.push_back(r);
            r.day = 5'd1; r.hour = 5'd24; pending_reqs.push_back(r);
            r.hour = 5'd0; r.minute = 6'd60; pending_reqs.push_back(r);
        end
        drain();

        for (phase = 0; phase < 4; phase++) begin
            sender_idle_pct    = (phase == 1) ? 48 : (phase == 3) ? 7 : 0;
            receiver_stall_pct = (phase == 2) ? 48 : (phase == 3) ? 7 : 0;
            push_random(250);
            drain();
        end
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        push_random(250);
        drain();
        repeat (400) @(posedge aclk);

        if (mismatches == 0 && expected_matches.size() == 0)
            $display("PASS timed_schedule_matcher");
        else
            $display("FAIL timed_schedule_matcher");
        $finish;
    end

endmodule

`default_nettype wire
